// ===== rtl/json_string_unescape_utf8_assert.svh =====
// Assertion macros for the JSON string decoder.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// Same-cycle implication.
`define JSU_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
`default_nettype none

package jsu_pkg;

    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Most results one input item can cause.
    localparam int NUM_RES = 4;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_DATA  = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_QUOTE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd1;
    localparam logic [2:0] ERR_BAD_LOW   = 3'd2;
    localparam logic [2:0] ERR_BAD_ESC   = 3'd3;
    localparam logic [2:0] ERR_CTRL      = 3'd4;
    localparam logic [2:0] ERR_UNTERM    = 3'd5;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] error_code;
        logic       last;
    } out_item_t;

    // One result without its last flag.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] error_code;
    } res_t;

    // All results of one input item; n counts 1 to NUM_RES.
    typedef struct packed {
        logic [2:0]         n;
        res_t [NUM_RES-1:0] res;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/json_string_unescape_utf8.sv =====
// An item's job is registered in the job queue, then each result in the output register.
// Throughput: one item per cycle at s_ while s_ready is high; m_ gives one result per cycle
// while m_ready allows. An item with k results (up to 4: UTF-8 bytes, U+FFFD plus one more)
// holds the back; the queue (QUEUE_DEPTH jobs) absorbs bursts, s_ready drops only when full.
// Reset: aresetn is synchronous, active low; it closes any open string and empties
// the queue and output register. No clearing pass follows.
`default_nettype none

module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire jsu_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output jsu_pkg::out_item_t      m_item
);

    // Front: decoder FSM, turns each accepted item into at most one job of results.
    // Queue: holds jobs so the front keeps accepting while the back drains a burst.
    // Back: walks the head job one result per cycle, unless stalled, to the output register.

    jsu_pkg::q_stat_t q_stat;
    jsu_pkg::job_t    push_job;
    jsu_pkg::job_t    head_job;
    logic             push;
    logic             pop;

    jsu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_stat  (q_stat),
        .push    (push),
        .job     (push_job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    jsu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

`include "json_string_unescape_utf8_assert.svh"

    // A quote or error result always closes its item's burst.
    `JSU_ASSERT_IMPLY(a_final_last, m_valid && (m_item.kind != jsu_pkg::KIND_BYTE), m_item.last, "quote or error result not marked last")

    // Only byte results carry a byte.
    `JSU_ASSERT_IMPLY(a_byte_zero, m_valid && (m_item.kind != jsu_pkg::KIND_BYTE), m_item.out_byte == 8'h00, "non-byte result with nonzero byte")

    // Only error results carry a code.
    `JSU_ASSERT_IMPLY(a_err_zero, m_valid && (m_item.kind != jsu_pkg::KIND_ERROR), m_item.error_code == jsu_pkg::ERR_NONE, "error code on a non-error result")

    // With nothing queued, a taken result leaves the output empty.
    `JSU_ASSERT_NEXT(a_drain, q_stat.empty && m_ready, !m_valid, "result invented from an empty queue")

endmodule

`default_nettype wire

// ===== rtl/jsu_front.sv =====
`default_nettype none

module jsu_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire jsu_pkg::in_item_t s_item,
    input  wire jsu_pkg::q_stat_t  q_stat,
    output logic                   push,
    output jsu_pkg::job_t          job
);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_BODY    = 3'd1;
    localparam logic [2:0] MODE_ESC     = 3'd2;
    localparam logic [2:0] MODE_HEX1    = 3'd3;
    localparam logic [2:0] MODE_AH      = 3'd4;
    localparam logic [2:0] MODE_AH_BS   = 3'd5;
    localparam logic [2:0] MODE_HEX2    = 3'd6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [20:0] CP_FFFD = 21'h00FFFD;

    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] b;
    } utf8_t;

    // Hex digit value, with bit 4 set when the byte is a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
            r = {1'b1, d[3:0]};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
            r = {1'b1, d[3:0]};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

    function automatic utf8_t utf8_enc(input logic [20:0] cp);
        utf8_t u;
        u = '0;
        if (cp < 21'h80) begin
            u.n    = 3'd1;
            u.b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            u.n    = 3'd2;
            u.b[0] = {3'b110, cp[10:6]};
            u.b[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            u.n    = 3'd3;
            u.b[0] = {4'b1110, cp[15:12]};
            u.b[1] = {2'b10, cp[11:6]};
            u.b[2] = {2'b10, cp[5:0]};
        end else begin
            u.n    = 3'd4;
            u.b[0] = {5'b11110, cp[20:18]};
            u.b[1] = {2'b10, cp[17:12]};
            u.b[2] = {2'b10, cp[11:6]};
            u.b[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

    function automatic jsu_pkg::res_t mk_byte(input logic [7:0] b);
        return jsu_pkg::res_t'{jsu_pkg::KIND_BYTE, b, jsu_pkg::ERR_NONE};
    endfunction

    function automatic jsu_pkg::res_t mk_err(input logic [2:0] e);
        return jsu_pkg::res_t'{jsu_pkg::KIND_ERROR, 8'h00, e};
    endfunction

    logic [2:0]  mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  high_reg, high_next;

    logic        accept;
    logic [7:0]  b;
    logic [4:0]  hex;
    logic [15:0] acc_shift;

    jsu_pkg::res_t body_res, esc_res, single;
    logic          body_v, esc_v, esc_u, single_v;
    logic [2:0]    body_mode, esc_mode;

    logic          fffd, use_utf8;
    logic [20:0]   cp;
    utf8_t         enc;

    assign s_ready   = !q_stat.full;
    assign accept    = s_valid && s_ready;
    assign b         = s_item.in_byte;
    assign hex       = hex_digit(b);
    assign acc_shift = {acc_reg[11:0], hex[3:0]};

    // Plain string byte.
    always_comb begin
        body_res  = mk_byte(b);
        body_v    = 1'b1;
        body_mode = MODE_BODY;
        if (b == CH_QUOTE) begin
            body_res  = jsu_pkg::res_t'{jsu_pkg::KIND_QUOTE, 8'h00, jsu_pkg::ERR_NONE};
            body_mode = MODE_IDLE;
        end else if (b == CH_BSLASH) begin
            body_v    = 1'b0;
            body_mode = MODE_ESC;
        end else if (b < CH_SPACE) begin
            body_res  = mk_err(jsu_pkg::ERR_CTRL);
            body_mode = MODE_IDLE;
        end
    end

    // Letter after a backslash.
    always_comb begin
        esc_res  = mk_byte(b);
        esc_v    = 1'b1;
        esc_u    = 1'b0;
        esc_mode = MODE_BODY;
        case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_res = mk_byte(b);
            CH_B: esc_res = mk_byte(8'h08);
            CH_F: esc_res = mk_byte(8'h0C);
            CH_N: esc_res = mk_byte(8'h0A);
            CH_R: esc_res = mk_byte(8'h0D);
            CH_T: esc_res = mk_byte(8'h09);
            CH_U: begin
                esc_v    = 1'b0;
                esc_u    = 1'b1;
                esc_mode = MODE_HEX1;
            end
            default: begin
                esc_res  = mk_err(jsu_pkg::ERR_BAD_ESC);
                esc_mode = MODE_IDLE;
            end
        endcase
    end

    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        high_next = high_reg;
        fffd      = 1'b0;
        use_utf8  = 1'b0;
        cp        = '0;
        single    = mk_byte(8'h00);
        single_v  = 1'b0;
        if (accept) begin
            case (s_item.func)
                jsu_pkg::FUNC_START: begin
                    mode_next = MODE_BODY;
                    acc_next  = '0;
                    cnt_next  = '0;
                    high_next = '0;
                end
                jsu_pkg::FUNC_DATA: begin
                    case (mode_reg)
                        MODE_BODY: begin
                            single    = body_res;
                            single_v  = body_v;
                            mode_next = body_mode;
                        end
                        MODE_ESC: begin
                            single    = esc_res;
                            single_v  = esc_v;
                            mode_next = esc_mode;
                            if (esc_u) begin
                                acc_next = '0;
                                cnt_next = '0;
                            end
                        end
                        MODE_HEX1: begin
                            if (!hex[4]) begin
                                single    = mk_err(jsu_pkg::ERR_BAD_HEX);
                                single_v  = 1'b1;
                                mode_next = MODE_IDLE;
                            end else begin
                                acc_next = acc_shift;
                                cnt_next = cnt_reg + 2'd1;
                                if (cnt_reg == 2'd3) begin
                                    if (acc_shift >= 16'hD800 && acc_shift <= 16'hDBFF) begin
                                        // Low ten bits equal the offset from 0xD800.
                                        high_next = acc_shift[9:0];
                                        mode_next = MODE_AH;
                                    end else begin
                                        use_utf8  = 1'b1;
                                        cp        = {5'b00000, acc_shift};
                                        mode_next = MODE_BODY;
                                    end
                                end
                            end
                        end
                        MODE_AH: begin
                            if (b == CH_BSLASH) begin
                                mode_next = MODE_AH_BS;
                            end else begin
                                fffd      = 1'b1;
                                single    = body_res;
                                single_v  = body_v;
                                mode_next = body_mode;
                            end
                        end
                        MODE_AH_BS: begin
                            if (b == CH_U) begin
                                mode_next = MODE_HEX2;
                                acc_next  = '0;
                                cnt_next  = '0;
                            end else begin
                                fffd      = 1'b1;
                                single    = esc_res;
                                single_v  = esc_v;
                                mode_next = esc_mode;
                            end
                        end
                        MODE_HEX2: begin
                            if (!hex[4]) begin
                                single    = mk_err(jsu_pkg::ERR_BAD_LOW);
                                single_v  = 1'b1;
                                mode_next = MODE_IDLE;
                            end else begin
                                acc_next = acc_shift;
                                cnt_next = cnt_reg + 2'd1;
                                if (cnt_reg == 2'd3) begin
                                    use_utf8  = 1'b1;
                                    mode_next = MODE_BODY;
                                    if (acc_shift >= 16'hDC00 && acc_shift <= 16'hDFFF) begin
                                        cp = 21'h010000 + {1'b0, high_reg, acc_shift[9:0]};
                                    end else begin
                                        cp = CP_FFFD;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                jsu_pkg::FUNC_END: begin
                    mode_next = MODE_IDLE;
                    case (mode_reg)
                        MODE_BODY, MODE_ESC: begin
                            single   = mk_err(jsu_pkg::ERR_UNTERM);
                            single_v = 1'b1;
                        end
                        MODE_HEX1: begin
                            single   = mk_err(jsu_pkg::ERR_BAD_HEX);
                            single_v = 1'b1;
                        end
                        MODE_AH, MODE_AH_BS: begin
                            fffd     = 1'b1;
                            single   = mk_err(jsu_pkg::ERR_UNTERM);
                            single_v = 1'b1;
                        end
                        MODE_HEX2: begin
                            single   = mk_err(jsu_pkg::ERR_BAD_LOW);
                            single_v = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    assign enc = utf8_enc(cp);

    // Pack the results: an encoded code point, or an optional U+FFFD then at most one result.
    always_comb begin
        job.n   = '0;
        job.res = '0;
        if (use_utf8) begin
            job.n = enc.n;
            for (int i = 0; i < jsu_pkg::NUM_RES; i++) begin
                job.res[i] = mk_byte(enc.b[i]);
            end
        end else if (fffd) begin
            job.n      = 3'd3 + {2'b00, single_v};
            job.res[0] = mk_byte(8'hEF);
            job.res[1] = mk_byte(8'hBF);
            job.res[2] = mk_byte(8'hBD);
            job.res[3] = single;
        end else begin
            job.n      = {2'b00, single_v};
            job.res[0] = single;
        end
    end

    assign push = accept && (job.n != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            high_reg <= '0;
        end else begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            high_reg <= high_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jsu_queue.sv =====
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire jsu_pkg::job_t    push_job,
    input  wire logic             pop,
    output jsu_pkg::job_t         head_job,
    output jsu_pkg::q_stat_t      q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::job_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_job     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jsu_back.sv =====
`default_nettype none

module jsu_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire jsu_pkg::job_t     head_job,
    input  wire jsu_pkg::q_stat_t  q_stat,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output jsu_pkg::out_item_t     m_item
);

    logic [1:0]         idx_reg, idx_next;
    logic               m_valid_reg, m_valid_next;
    jsu_pkg::out_item_t m_item_reg, m_item_next;
    logic               load, is_last;
    jsu_pkg::res_t      cur;

    assign load    = !q_stat.empty && (!m_valid_reg || m_ready);
    assign cur     = head_job.res[idx_reg];
    assign is_last = ({1'b0, idx_reg} == (head_job.n - 3'd1));
    assign pop     = load && is_last;

    always_comb begin
        idx_next     = idx_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (load) begin
            m_valid_next = 1'b1;
            m_item_next  = jsu_pkg::out_item_t'{cur.kind, cur.out_byte, cur.error_code, is_last};
            // Advance within the job; drop back to the first result once it is done.
            idx_next     = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire
